>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/iirdf1_pkg.sv
// types, constants and the control store of the direct form one filter
package iirdf1_pkg;

	localparam int ORDER    = 3;
	localparam int HIST_D   = 3;
	localparam int NUM_REGS = 7;
	localparam int SMP_W    = 16;
	localparam int COEF_W   = 18;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = SMP_W + COEF_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int FRAC_SH  = 14;
	localparam int YF_W     = ACC_W - FRAC_SH;
	localparam int PC_W     = 4;
	localparam int TAP_W    = 3;

	// tap codes: coefficient and the operand it multiplies
	localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
	localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
	localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
	localparam logic [TAP_W-1:0] TAP_B3 = 3'd3;
	localparam logic [TAP_W-1:0] TAP_A1 = 3'd4;
	localparam logic [TAP_W-1:0] TAP_A2 = 3'd5;
	localparam logic [TAP_W-1:0] TAP_A3 = 3'd6;

	// program labels
	localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] PC_FIRST  = 4'd1;
	localparam logic [PC_W-1:0] PC_FINISH = 4'd9;
	localparam logic [PC_W-1:0] PC_CLEAR  = 4'd10;

	typedef enum logic [1:0] {
		H_NONE,
		H_NO_IN,
		H_OUT_FULL
	} hold_t;

	typedef enum logic [1:0] {
		J_NEVER,
		J_ALWAYS,
		J_CLEAR
	} jmp_t;

	typedef enum logic [1:0] {
		MAC_NONE,
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_t;

	typedef struct packed {
		hold_t            hold;
		jmp_t             jmp;
		logic [PC_W-1:0]  tgt;
		logic [TAP_W-1:0] tap;
		mac_t             mac;
		logic             take;
		logic             finish;
		logic             clear;
	} uword_t;

	// control bundle from sequencer to datapath
	typedef struct packed {
		logic [TAP_W-1:0] tap;
		mac_t             mac;
		logic             take;
		logic             finish;
		logic             clear;
	} ctl_t;

	function automatic uword_t uw(hold_t h, jmp_t j, logic [PC_W-1:0] t,
			logic [TAP_W-1:0] tp, mac_t m, logic tk, logic fin, logic clr);
		uword_t w;
		w.hold   = h;
		w.jmp    = j;
		w.tgt    = t;
		w.tap    = tp;
		w.mac    = m;
		w.take   = tk;
		w.finish = fin;
		w.clear  = clr;
		return w;
	endfunction

	// control store
	function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			4'd0:    w = uw(H_NO_IN, J_NEVER, PC_IDLE, TAP_B0, MAC_NONE, 1'b1, 1'b0, 1'b0);
			4'd1:    w = uw(H_NONE, J_CLEAR, PC_CLEAR, TAP_B0, MAC_LOAD, 1'b0, 1'b0, 1'b0);
			4'd2:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_B1, MAC_ADD, 1'b0, 1'b0, 1'b0);
			4'd3:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_B2, MAC_ADD, 1'b0, 1'b0, 1'b0);
			4'd4:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_B3, MAC_ADD, 1'b0, 1'b0, 1'b0);
			4'd5:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_A1, MAC_SUB, 1'b0, 1'b0, 1'b0);
			4'd6:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_A2, MAC_SUB, 1'b0, 1'b0, 1'b0);
			4'd7:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_A3, MAC_SUB, 1'b0, 1'b0, 1'b0);
			4'd8:    w = uw(H_NONE, J_NEVER, PC_IDLE, TAP_B0, MAC_NONE, 1'b0, 1'b0, 1'b0);
			4'd9:    w = uw(H_OUT_FULL, J_ALWAYS, PC_IDLE, TAP_B0, MAC_NONE,
					1'b0, 1'b1, 1'b0);
			4'd10:   w = uw(H_OUT_FULL, J_ALWAYS, PC_IDLE, TAP_B0, MAC_NONE,
					1'b0, 1'b0, 1'b1);
			default: w = uw(H_NONE, J_ALWAYS, PC_IDLE, TAP_B0, MAC_NONE, 1'b0, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

	// taps past the filter order contribute nothing
	function automatic logic tap_used(logic [TAP_W-1:0] tap);
		logic u;
		if (tap <= TAP_B3) begin
			u = (32'(tap) <= ORDER);
		end else if (tap <= TAP_A3) begin
			u = (32'(tap) - 32'(TAP_B3) <= ORDER);
		end else begin
			u = 1'b0;
		end
		return u;
	endfunction

endpackage

>>> hw/rtl/iirdf1_seq.sv
// microcode sequencer: step counter, control store and jump logic
module iirdf1_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_full,
	input  logic                 kind_q,
	output logic                 in_ready,
	output iirdf1_pkg::ctl_t     ctl
);
	import iirdf1_pkg::*;

	logic [PC_W-1:0] pc_q;
	uword_t          w;
	logic            hold;
	logic            jump;

	assign w = ucode_rom(pc_q);

	assign hold = ((w.hold == H_NO_IN) && !in_valid) ||
		((w.hold == H_OUT_FULL) && out_full);
	assign jump = (w.jmp == J_ALWAYS) || ((w.jmp == J_CLEAR) && kind_q);

	assign in_ready   = w.take;
	assign ctl.tap    = w.tap;
	assign ctl.mac    = w.mac;
	assign ctl.take   = w.take & ~hold;
	assign ctl.finish = w.finish & ~hold;
	assign ctl.clear  = w.clear & ~hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (!hold) begin
			pc_q <= jump ? w.tgt : pc_q + PC_W'(1);
		end
	end
endmodule

>>> hw/rtl/iirdf1_dp.sv
// datapath: coefficient and history registers, shared mac, rounding and output register
module iirdf1_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  iirdf1_pkg::ctl_t                        ctl,
	input  logic                                    kind,
	input  logic signed [iirdf1_pkg::SMP_W-1:0]     sample_in,
	input  logic                                    cfg_we,
	input  logic        [iirdf1_pkg::IDX_W-1:0]     cfg_index,
	input  logic signed [iirdf1_pkg::COEF_W-1:0]    cfg_data,
	input  logic                                    out_ready,
	output logic                                    kind_q,
	output logic                                    out_full,
	output logic                                    out_valid,
	output logic signed [iirdf1_pkg::SMP_W-1:0]     sample_out,
	output logic                                    saturated
);
	import iirdf1_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1 << (FRAC_SH - 1));
	localparam logic signed [YF_W-1:0]  Y_MAX   = YF_W'((1 << (SMP_W - 1)) - 1);
	localparam logic signed [YF_W-1:0]  Y_MIN   = -YF_W'(1 << (SMP_W - 1));

	logic signed [COEF_W-1:0] coef_q [NUM_REGS];
	logic signed [SMP_W-1:0]  ih_q [HIST_D];
	logic signed [SMP_W-1:0]  yh_q [HIST_D];
	logic signed [SMP_W-1:0]  u_q;
	logic signed [SMP_W-1:0]  opnd;
	logic signed [COEF_W-1:0] coef;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	mac_t                     mac_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [YF_W-1:0]   y_full;
	logic signed [SMP_W-1:0]  y_sat;
	logic                     y_clip;
	logic                     out_vld_q;
	logic signed [SMP_W-1:0]  out_data_q;
	logic                     out_sat_q;

	always_comb begin
		case (ctl.tap)
			TAP_B0:  opnd = u_q;
			TAP_B1:  opnd = ih_q[0];
			TAP_B2:  opnd = ih_q[1];
			TAP_B3:  opnd = ih_q[2];
			TAP_A1:  opnd = yh_q[0];
			TAP_A2:  opnd = yh_q[1];
			TAP_A3:  opnd = yh_q[2];
			default: opnd = '0;
		endcase
		coef = tap_used(ctl.tap) ? coef_q[ctl.tap] : '0;
	end

	assign prod_c = coef * opnd;

	// round half up then clip
	assign y_full = acc_q[ACC_W-1:FRAC_SH];
	always_comb begin
		if (y_full > Y_MAX) begin
			y_sat  = Y_MAX[SMP_W-1:0];
			y_clip = 1'b1;
		end else if (y_full < Y_MIN) begin
			y_sat  = Y_MIN[SMP_W-1:0];
			y_clip = 1'b1;
		end else begin
			y_sat  = y_full[SMP_W-1:0];
			y_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we && (32'(cfg_index) < NUM_REGS)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_D; i++) begin
				ih_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < HIST_D; i++) begin
				ih_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else if (ctl.finish) begin
			for (int i = HIST_D - 1; i > 0; i--) begin
				ih_q[i] <= ih_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
			ih_q[0] <= u_q;
			yh_q[0] <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
			mac_s1 <= MAC_NONE;
			out_vld_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				kind_q <= kind;
			end
			mac_s1 <= ctl.mac;
			if (ctl.finish || ctl.clear) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			u_q <= sample_in;
		end
		prod_s1 <= prod_c;
		case (mac_s1)
			MAC_LOAD: acc_q <= ACC_RND + ACC_W'(prod_s1);
			MAC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			MAC_SUB:  acc_q <= acc_q - ACC_W'(prod_s1);
			default:  acc_q <= acc_q;
		endcase
		if (ctl.finish) begin
			out_data_q <= y_sat;
			out_sat_q  <= y_clip;
		end else if (ctl.clear) begin
			out_data_q <= '0;
			out_sat_q  <= 1'b0;
		end
	end

	assign out_full   = out_vld_q & ~out_ready;
	assign out_valid  = out_vld_q;
	assign sample_out = out_data_q;
	assign saturated  = out_sat_q;
endmodule

>>> hw/rtl/iir_direct_form_one_filter.sv
// top level of the direct form one recursive filter, order up to three
// each item is taken one at a time; a sample item runs seven products through one shared mac
// and a product register, then a final accumulate step and a round/clip step that loads the
// output register; a clear item instead zeroes the histories and the output register
// the next item is accepted while a finished result still waits in the output register
// reset (arst_n low, asynchronous): coefficients and histories zero, sequencer idle
module iir_direct_form_one_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input items
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [iirdf1_pkg::SMP_W-1:0]         s_axis_tdata,  // [15:0] sample_in
	input  logic                                 s_axis_tuser,  // [0] kind (1 = clear)
	// result items
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [iirdf1_pkg::SMP_W-1:0]         m_axis_tdata,  // [15:0] sample_out
	output logic                                 m_axis_tuser,  // [0] saturated
	// coefficient writes: 0..3 = b0..b3, 4..6 = a1..a3
	input  logic                                 cfg_we,
	input  logic [iirdf1_pkg::IDX_W-1:0]         cfg_index,
	input  logic [iirdf1_pkg::COEF_W-1:0]        cfg_data
);
	import iirdf1_pkg::*;

	ctl_t                     ctl;      // control word fields for this step
	logic                     kind_q;   // kind of the item in progress
	logic                     out_full; // output register occupied and not drained
	logic signed [SMP_W-1:0]  y_out;

	// step counter and control store
	iirdf1_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_full (out_full),
		.kind_q   (kind_q),
		.in_ready (s_axis_tready),
		.ctl      (ctl)
	);

	// mac, histories, coefficient registers and output register
	iirdf1_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.kind       (s_axis_tuser),
		.sample_in  ($signed(s_axis_tdata)),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   ($signed(cfg_data)),
		.out_ready  (m_axis_tready),
		.kind_q     (kind_q),
		.out_full   (out_full),
		.out_valid  (m_axis_tvalid),
		.sample_out (y_out),
		.saturated  (m_axis_tuser)
	);

	assign m_axis_tdata = y_out;
endmodule

>>> hw/rtl/iirdf1_checker.sv
// port-level checker for the direct form one filter and its bind
`include "assert_macros.svh"

module iirdf1_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [iirdf1_pkg::SMP_W-1:0]   m_axis_tdata,
	input logic                           m_axis_tuser
);
	// a stalled result keeps its value
	`ASSERT_AT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// one item in flight: ready drops right after an accept
	`ASSERT_AT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while busy")

	// a clipped result sits on a range limit
	`ASSERT_AT(a_sat_value, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000, "saturated flag without limit value")

	// no new result in the cycle right after an accept
	`ASSERT_NEVER(a_no_instant_result, $rose(m_axis_tvalid) && $past(s_axis_tvalid && s_axis_tready), "result appeared too early")
endmodule

bind iir_direct_form_one_filter iirdf1_checker u_chk (.*);

>>> verif/iir_direct_form_one_filter_tb.sv
// self-checking testbench of the direct form one recursive filter
module iir_direct_form_one_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iirdf1_pkg::*;

	// coefficient register indexes, b0..b3 then a1..a3, 7 lies outside the map
	localparam logic [IDX_W-1:0] REG_NUM0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_NUM1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_NUM2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_NUM3 = 3'd3;
	localparam logic [IDX_W-1:0] REG_DEN1 = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEN2 = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEN3 = 3'd6;
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	// item kinds carried on tuser
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam int N_PHASES        = 6;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int PLAN_LEN        = 43;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_CLEAR,
		ROW_WRITE
	} row_op_t;

	// one row of the directed plan; y and sat only count where known is set
	typedef struct packed {
		row_op_t                  op;
		logic [IDX_W-1:0]         idx;
		logic signed [COEF_W-1:0] val;
		logic                     known;
		logic [SMP_W-1:0]         y;
		logic                     sat;
	} row_t;

	typedef struct {
		logic [SMP_W-1:0] y;
		logic             sat;
	} filt_out_t;

	// directed plan: zero coefficients after reset, unity gain, clipping both ways,
	// rounding at the half step, clear, mixed taps, ignored index, extreme taps
	localparam row_t PLAN [PLAN_LEN] = '{
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b1, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE, -18'sd32768, 1'b1, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM0,  18'sd16384, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b1, 16'h7FFF, 1'b0},
		'{ROW_SAMPLE, REG_NONE, -18'sd32768, 1'b1, 16'h8000, 1'b0},
		'{ROW_WRITE,  REG_NUM0, 18'sd131071, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b1, 16'h7FFF, 1'b1},
		'{ROW_SAMPLE, REG_NONE, -18'sd32768, 1'b1, 16'h8000, 1'b1},
		'{ROW_WRITE,  REG_NUM0, -18'sd131072, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE, -18'sd32768, 1'b1, 16'h7FFF, 1'b1},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b1, 16'h8000, 1'b1},
		'{ROW_CLEAR,  REG_NONE,   18'sd1234, 1'b1, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM0,      18'sd1, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,   18'sd8192, 1'b1, 16'h0001, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  -18'sd8192, 1'b1, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,   18'sd8191, 1'b1, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  -18'sd8193, 1'b1, 16'hFFFF, 1'b0},
		'{ROW_WRITE,  REG_NUM0,  18'sd16384, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM1,   18'sd8192, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM2,  -18'sd8192, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM3,   18'sd4096, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_DEN1,  -18'sd8192, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_DEN2,   18'sd4096, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_DEN3,  -18'sd2048, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd20000, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE, -18'sd15000, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE, -18'sd32768, 1'b0, 16'h0000, 1'b0},
		'{ROW_CLEAR,  REG_NONE, -18'sd4321, 1'b1, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,   18'sd1000, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NONE, 18'sd131071, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  -18'sd1000, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM1, 18'sd131071, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM2, -18'sd131072, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_NUM3, 18'sd131071, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_DEN1, -18'sd131072, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_DEN2, 18'sd131071, 1'b0, 16'h0000, 1'b0},
		'{ROW_WRITE,  REG_DEN3, -18'sd131072, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd32767, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE, -18'sd32768, 1'b0, 16'h0000, 1'b0},
		'{ROW_SAMPLE, REG_NONE,  18'sd12345, 1'b0, 16'h0000, 1'b0}
	};

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [SMP_W-1:0]     s_axis_tdata  = '0;  // [15:0] sample_in
	logic                 s_axis_tuser  = 1'b0;  // [0] kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [SMP_W-1:0]     m_axis_tdata;  // [15:0] sample_out
	logic                 m_axis_tuser;  // [0] saturated
	logic                 cfg_we        = 1'b0;
	logic [IDX_W-1:0]     cfg_index     = '0;
	logic [COEF_W-1:0]    cfg_data      = '0;

	// predictor state: coefficients in register order, sample and output histories
	logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
	logic signed [SMP_W-1:0]  hist_u [HIST_D];
	logic signed [SMP_W-1:0]  hist_y [HIST_D];

	filt_out_t expected_outputs [$];
	filt_out_t rx_want;
	int        mismatch_count = 0;
	int        rx_stall_left  = 0;
	bit        idling         = 1'b1;

	iir_direct_form_one_filter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatch_count++;
	endtask

	// one filter step: exact sum of products, round half up to q1.15, clip,
	// then the clipped value feeds back; a clear zeroes both histories
	function automatic filt_out_t predict_filter_output(logic k, logic signed [SMP_W-1:0] u);
		filt_out_t          res;
		logic signed [63:0] acc;
		logic signed [63:0] yq;
		int                 i;
		res.sat = 1'b0;
		if (k == KIND_CLEAR) begin
			for (i = 0; i < HIST_D; i++) begin
				hist_u[i] = '0;
				hist_y[i] = '0;
			end
			res.y = '0;
			return res;
		end
		acc = coef_reg[REG_NUM0] * u;
		// taps past the order stay out of the sum
		for (i = 1; i <= ORDER; i++) begin
			acc = acc + coef_reg[REG_NUM0 + i] * hist_u[i-1];
			acc = acc - coef_reg[REG_DEN1 + i - 1] * hist_y[i-1];
		end
		// add half an lsb, then floor by the arithmetic shift
		yq = (acc + 64'sd8192) >>> 14;
		if (yq > 64'sd32767) begin
			yq = 64'sd32767;
			res.sat = 1'b1;
		end else if (yq < -64'sd32768) begin
			yq = -64'sd32768;
			res.sat = 1'b1;
		end
		for (i = HIST_D - 1; i > 0; i--) begin
			hist_u[i] = hist_u[i-1];
			hist_y[i] = hist_y[i-1];
		end
		hist_u[0] = u;
		hist_y[0] = yq[SMP_W-1:0];
		res.y = yq[SMP_W-1:0];
		return res;
	endfunction

	// offer one item, wait for the handshake, then log what should come back;
	// where known is set the typed result stands in for the prediction
	task automatic send_item(input logic k, input logic [SMP_W-1:0] smp, input logic known,
			input logic [SMP_W-1:0] ky, input logic ksat);
		filt_out_t pred;
		cfg_we <= 1'b0;
		// random gap before the item
		if (idling && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= k;
		do @(posedge clk); while (!s_axis_tready);
		pred = predict_filter_output(k, smp);
		if (known) begin
			pred.y   = ky;
			pred.sat = ksat;
		end
		expected_outputs.push_back(pred);
	endtask

	// stop offering items and hold until every pending result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_outputs.size() != 0) @(posedge clk);
	endtask

	// one register write; the caller has drained, the next item lowers the enable
	task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		// an index outside the map is dropped
		if (idx < NUM_REGS)
			coef_reg[idx] = val;
	endtask

	// result side: check each accepted item, stall in random bursts while idling is set
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with none pending", m_axis_tdata));
			end else begin
				rx_want = expected_outputs.pop_front();
				if (m_axis_tdata !== rx_want.y)
					report_mismatch($sformatf("sample_out %h, expected %h",
						m_axis_tdata, rx_want.y));
				if (m_axis_tuser !== rx_want.sat)
					report_mismatch($sformatf("saturated %b, expected %b",
						m_axis_tuser, rx_want.sat));
			end
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			rx_stall_left = $urandom_range(1, 10);
		end
		m_axis_tready <= (rx_stall_left == 0);
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int                       r;
		int                       phase;
		int                       n;
		int                       pick;
		int                       tmp;
		logic [SMP_W-1:0]         smp;
		logic                     k;
		logic signed [COEF_W-1:0] cv;

		for (r = 0; r < NUM_REGS; r++)
			coef_reg[r] = '0;
		for (r = 0; r < HIST_D; r++) begin
			hist_u[r] = '0;
			hist_y[r] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (r = 0; r < PLAN_LEN; r++) begin
			case (PLAN[r].op)
				ROW_WRITE: begin
					drain_results();
					write_coef(PLAN[r].idx, PLAN[r].val);
				end
				ROW_CLEAR: begin
					send_item(KIND_CLEAR, PLAN[r].val[SMP_W-1:0], PLAN[r].known,
						PLAN[r].y, PLAN[r].sat);
				end
				default: begin
					send_item(KIND_SAMPLE, PLAN[r].val[SMP_W-1:0], PLAN[r].known,
						PLAN[r].y, PLAN[r].sat);
				end
			endcase
		end

		// random phases, each with its own coefficient set; the last one runs flat out
		for (phase = 0; phase < N_PHASES; phase++) begin
			drain_results();
			idling = (phase != N_PHASES - 1);
			for (r = 0; r < NUM_REGS; r++) begin
				case (phase % 4)
					// anything goes, mostly clipping
					0: cv = COEF_W'($urandom());
					// small taps, feedback gain well under one
					1: begin
						if (r < REG_DEN1)
							tmp = $urandom_range(0, 16383) - 8192;
						else
							tmp = $urandom_range(0, 5460) - 2730;
						cv = COEF_W'(tmp);
					end
					// each tap at a rail or zero
					2: begin
						case ($urandom_range(0, 2))
							0:       cv = 18'sd131071;
							1:       cv = -18'sd131072;
							default: cv = '0;
						endcase
					end
					// first order section only
					default: begin
						if (r == REG_NUM0 || r == REG_NUM1)
							tmp = $urandom_range(0, 32768) - 16384;
						else if (r == REG_DEN1)
							tmp = $urandom_range(0, 24000) - 12000;
						else
							tmp = 0;
						cv = COEF_W'(tmp);
					end
				endcase
				write_coef(IDX_W'(r), cv);
			end
			if ($urandom_range(0, 1) == 1)
				write_coef(REG_NONE, COEF_W'($urandom()));

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// now and then let the pipeline run dry
				if (idling && $urandom_range(0, 63) == 0)
					drain_results();
				pick = $urandom_range(0, 15);
				k    = (pick == 0) ? KIND_CLEAR : KIND_SAMPLE;
				case (pick)
					1, 2:    smp = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
					3, 4:    smp = SMP_W'($urandom_range(0, 512)) - 16'd256;
					default: smp = SMP_W'($urandom());
				endcase
				send_item(k, smp, 1'b0, '0, 1'b0);
			end
		end

		drain_results();
		// keep the clock running to catch any stray result
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_outputs.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
